// ===== rtl/rhsm_pkg.sv =====
// Shared types, codes and modulo-101 arithmetic for the rolling hash string matcher.
package rhsm_pkg;

   localparam int HASH_BASE = 256;
   localparam int HASH_MOD  = 101;
   localparam int CHAR_W    = 8;
   localparam int HASH_W    = 7;
   localparam int OUT_IDX_W = 16;

   typedef enum logic [1:0] {
      OP_RESTART = 2'd0,
      OP_PATTERN = 2'd1,
      OP_TEXT    = 2'd2
   } opcode_type;

   localparam logic [1:0] STATUS_OK           = 2'd0;
   localparam logic [1:0] STATUS_PATTERN_FULL = 2'd1;
   localparam logic [1:0] STATUS_NOT_READY    = 2'd2;
   localparam logic [1:0] STATUS_SATURATED    = 2'd3;

   typedef struct packed {
      logic shift_window;
      logic shift_pattern;
      logic active;
      logic last;
   } cell_ctrl_type;

   typedef struct packed {
      logic                 match_found;
      logic [OUT_IDX_W-1:0] match_index;
      logic                 hash_hit;
      logic [HASH_W-1:0]    window_hash;
      logic [1:0]           status;
   } result_type;

   typedef logic [127:0][HASH_W-1:0] mod_table_type;

   function automatic mod_table_type build_mul256_table();
      mod_table_type t;
      for (int i = 0; i < 128; i++) begin
         t[i] = HASH_W'((i * HASH_BASE) % HASH_MOD);
      end
      return t;
   endfunction

   // Entry v holds (v * 256) mod 101.
   localparam mod_table_type MUL256_TABLE = build_mul256_table();

   function automatic logic [HASH_W-1:0] mul256_mod(input logic [HASH_W-1:0] v);
      return MUL256_TABLE[v];
   endfunction

   function automatic logic [HASH_W-1:0] mod_byte(input logic [CHAR_W-1:0] v);
      logic [CHAR_W-1:0] r;
      if (v >= CHAR_W'(2 * HASH_MOD)) r = v - CHAR_W'(2 * HASH_MOD);
      else if (v >= CHAR_W'(HASH_MOD)) r = v - CHAR_W'(HASH_MOD);
      else r = v;
      return r[HASH_W-1:0];
   endfunction

   // Reduces a sum below three times the modulus.
   function automatic logic [HASH_W-1:0] mod_small(input logic [8:0] v);
      logic [8:0] r;
      if (v >= 9'(2 * HASH_MOD)) r = v - 9'(2 * HASH_MOD);
      else if (v >= 9'(HASH_MOD)) r = v - 9'(HASH_MOD);
      else r = v;
      return r[HASH_W-1:0];
   endfunction

   // A 15-bit product splits as high * 256 + low byte.
   function automatic logic [HASH_W-1:0] mod_product(input logic [14:0] p);
      return mod_small(9'(mul256_mod(p[14:8])) + 9'(mod_byte(p[7:0])));
   endfunction

endpackage

// ===== rtl/rhsm_if.sv =====
// Valid/ready channel interfaces for match requests and match results.
interface rhsm_req_if;
   logic       valid;
   logic       ready;
   logic [1:0] opcode;
   logic [7:0] char_value;

   modport source (output valid, output opcode, output char_value, input ready);
   modport sink (input valid, input opcode, input char_value, output ready);
endinterface

interface rhsm_rsp_if;
   logic        valid;
   logic        ready;
   logic        match_found;
   logic [15:0] match_index;
   logic        hash_hit;
   logic [6:0]  window_hash;
   logic [1:0]  status;

   modport source (output valid, output match_found, output match_index,
                   output hash_hit, output window_hash, output status, input ready);
   modport sink (input valid, input match_found, input match_index,
                 input hash_hit, input window_hash, input status, output ready);
endinterface

// ===== rtl/rhsm_cell.sv =====
// One cell of the window and pattern shift chains with its byte comparator.
module rhsm_cell import rhsm_pkg::*; (
   input  logic              clock,
   input  cell_ctrl_type     ctrl,
   input  logic [CHAR_W-1:0] win_prev,
   input  logic [CHAR_W-1:0] pat_prev,
   output logic [CHAR_W-1:0] win_out,
   output logic [CHAR_W-1:0] pat_out,
   output logic              agree,
   output logic [CHAR_W-1:0] tail_byte
);

   logic [CHAR_W-1:0] win_ff, win_in;
   logic [CHAR_W-1:0] pat_ff, pat_in;

   assign win_in = ctrl.shift_window ? win_prev : win_ff;
   assign pat_in = ctrl.shift_pattern ? pat_prev : pat_ff;

   always_ff @(posedge clock) begin
      win_ff <= win_in;
      pat_ff <= pat_in;
   end

   assign win_out = win_ff;
   assign pat_out = pat_ff;

   // The comparison looks at the byte this cell holds after the shift.
   assign agree     = !ctrl.active || (win_prev == pat_ff);
   assign tail_byte = ctrl.last ? win_ff : '0;

endmodule

// ===== rtl/rhsm_hash.sv =====
// Rolling hash update: drop the oldest byte, shift by the base, add the new byte.
module rhsm_hash import rhsm_pkg::*; (
   input  logic [HASH_W-1:0] hash_cur,
   input  logic [CHAR_W-1:0] char_value,
   input  logic [CHAR_W-1:0] oldest,
   input  logic [HASH_W-1:0] power,
   input  logic              was_full,
   output logic [HASH_W-1:0] hash_next
);

   logic [14:0]       product;
   logic [HASH_W-1:0] term;
   logic [8:0]        sum;

   // power holds 256^L mod 101, so the term already carries the base shift.
   assign product = 15'(oldest) * 15'(power);
   assign term    = was_full ? mod_product(product) : '0;
   assign sum     = 9'(mul256_mod(hash_cur)) + (9'(HASH_MOD) - 9'(term))
                  + 9'(mod_byte(char_value));
   assign hash_next = mod_small(sum);

endmodule

// ===== rtl/rolling_hash_string_match.sv =====
// Top level of the rolling hash string matcher.
// A result is registered in the cycle after its request transfer.
// Throughput: one request per cycle unless a held result stalls; a whole window
// is checked by the cell comparators in the cycle its byte enters the chain.
// Reset clears lengths, hashes, counters and the result valid at once;
// the byte stores are left as they are.
module rolling_hash_string_match import rhsm_pkg::*; #(
   parameter int MAX_PATTERN = 16,
   parameter int INDEX_WIDTH = 16
) (
   input logic       clock,
   input logic       reset,
   rhsm_req_if.sink  req_chan,
   rhsm_rsp_if.source rsp_chan
);

   localparam int LEN_W = $clog2(MAX_PATTERN + 1);

   logic [LEN_W-1:0]       len_ff, len_in;
   logic [HASH_W-1:0]      pattern_hash_ff, pattern_hash_in;
   logic [HASH_W-1:0]      power_ff, power_in;
   logic [HASH_W-1:0]      window_hash_ff, window_hash_in;
   logic [INDEX_WIDTH-1:0] count_ff, count_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   result_type             result_ff, result_in;

   logic                   accept;
   logic                   shift_window, shift_pattern;
   logic [CHAR_W-1:0]      char_value;

   logic [MAX_PATTERN-1:0]             agree_vec;
   logic [MAX_PATTERN-1:0][CHAR_W-1:0] tail_vec;
   logic [MAX_PATTERN-1:0][CHAR_W-1:0] win_q;
   logic [MAX_PATTERN-1:0][CHAR_W-1:0] pat_q;
   logic [CHAR_W-1:0]                  oldest;

   logic [INDEX_WIDTH-1:0] len_ext, count_step, start;
   logic                   was_full, saturated, full_after, hit, found;
   logic [HASH_W-1:0]      hash_next;
   logic [31:0]            start_wide;

   assign char_value   = req_chan.char_value;
   assign req_chan.ready = !rsp_valid_ff || rsp_chan.ready;
   assign accept       = req_chan.valid && req_chan.ready;

   assign shift_window  = accept && (req_chan.opcode == OP_TEXT) && (len_ff != '0);
   assign shift_pattern = accept && (req_chan.opcode == OP_PATTERN)
                        && (len_ff < LEN_W'(MAX_PATTERN));

   for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_cell
      cell_ctrl_type ctrl;
      assign ctrl.shift_window  = shift_window;
      assign ctrl.shift_pattern = shift_pattern;
      assign ctrl.active        = len_ff > LEN_W'(j);
      assign ctrl.last          = len_ff == LEN_W'(j + 1);

      rhsm_cell u_cell (
         .clock     (clock),
         .ctrl      (ctrl),
         .win_prev  ((j == 0) ? char_value : win_q[(j == 0) ? 0 : j - 1]),
         .pat_prev  ((j == 0) ? char_value : pat_q[(j == 0) ? 0 : j - 1]),
         .win_out   (win_q[j]),
         .pat_out   (pat_q[j]),
         .agree     (agree_vec[j]),
         .tail_byte (tail_vec[j])
      );
   end

   // At most one cell is the last active one, so an OR picks its byte.
   always_comb begin
      oldest = '0;
      for (int j = 0; j < MAX_PATTERN; j++) begin
         oldest = oldest | tail_vec[j];
      end
   end

   assign len_ext   = INDEX_WIDTH'(len_ff);
   assign was_full  = count_ff >= len_ext;
   assign saturated = &count_ff;

   rhsm_hash u_hash (
      .hash_cur   (window_hash_ff),
      .char_value (char_value),
      .oldest     (oldest),
      .power      (power_ff),
      .was_full   (was_full),
      .hash_next  (hash_next)
   );

   assign count_step = saturated ? count_ff : count_ff + 1'b1;
   assign full_after = count_step >= len_ext;
   assign hit        = hash_next == pattern_hash_ff;
   assign found      = hit && (&agree_vec);
   assign start      = count_step - len_ext;
   assign start_wide = 32'(start);

   always_comb begin
      len_in          = len_ff;
      pattern_hash_in = pattern_hash_ff;
      power_in        = power_ff;
      window_hash_in  = window_hash_ff;
      count_in        = count_ff;
      rsp_valid_in    = rsp_valid_ff && !rsp_chan.ready;
      result_in       = result_ff;

      if (accept) begin
         rsp_valid_in = 1'b1;
         result_in    = '0;
         unique case (opcode_type'(req_chan.opcode))
            OP_RESTART: begin
               len_in          = '0;
               pattern_hash_in = '0;
               power_in        = HASH_W'(1);
               window_hash_in  = '0;
               count_in        = '0;
            end
            OP_PATTERN: begin
               if (shift_pattern) begin
                  len_in          = len_ff + 1'b1;
                  pattern_hash_in = mod_small(9'(mul256_mod(pattern_hash_ff))
                                              + 9'(mod_byte(char_value)));
                  power_in        = mul256_mod(power_ff);
               end else begin
                  result_in.status = STATUS_PATTERN_FULL;
               end
               window_hash_in = '0;
               count_in       = '0;
            end
            OP_TEXT: begin
               if (len_ff == '0) begin
                  result_in.window_hash = window_hash_ff;
                  result_in.status      = STATUS_NOT_READY;
               end else begin
                  window_hash_in        = hash_next;
                  count_in              = count_step;
                  result_in.window_hash = hash_next;
                  if (!full_after) begin
                     result_in.status = STATUS_NOT_READY;
                  end else if (saturated) begin
                     result_in.hash_hit = hit;
                     result_in.status   = STATUS_SATURATED;
                  end else begin
                     result_in.hash_hit    = hit;
                     result_in.match_found = found;
                     result_in.match_index = found ? start_wide[OUT_IDX_W-1:0] : '0;
                     result_in.status      = STATUS_OK;
                  end
               end
            end
            default: begin
               result_in.window_hash = window_hash_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff          <= '0;
         pattern_hash_ff <= '0;
         power_ff        <= HASH_W'(1);
         window_hash_ff  <= '0;
         count_ff        <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         len_ff          <= len_in;
         pattern_hash_ff <= pattern_hash_in;
         power_ff        <= power_in;
         window_hash_ff  <= window_hash_in;
         count_ff        <= count_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.match_found = result_ff.match_found;
   assign rsp_chan.match_index = result_ff.match_index;
   assign rsp_chan.hash_hit    = result_ff.hash_hit;
   assign rsp_chan.window_hash = result_ff.window_hash;
   assign rsp_chan.status      = result_ff.status;

endmodule
